[rtl/ccif_pkg.sv]
// Shared types, constants and calendar helpers for the calendar clock block.
package ccif_pkg;

	// Item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_LOAD  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PERIOD  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_INTERVAL = 4'd1;

	localparam logic [15:0] SYNC_PERIOD_RESET  = 16'd900;
	localparam logic [11:0] LOG_INTERVAL_RESET = 12'd5;
	localparam logic [11:0] LOG_INTERVAL_MIN   = 12'd5;

	localparam logic [15:0] YEAR_RESET = 16'd2000;
	localparam logic [5:0]  SEC_PER_MIN = 6'd60;
	localparam logic [5:0]  MIN_PER_HOUR = 6'd60;
	localparam logic [4:0]  HOUR_PER_DAY = 5'd24;
	localparam logic [3:0]  MONTH_PER_YEAR = 4'd12;
	localparam logic [3:0]  MONTH_FEB = 4'd2;

	// y divisible by 25 <=> (y * inverse(25) mod 2^16) <= floor(65535 / 25)
	localparam logic [15:0] INV25_MOD16 = 16'd23593;
	localparam logic [15:0] DIV25_LIMIT = 16'd2621;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] load_year;
		logic [3:0]  load_month;
		logic [4:0]  load_day;
		logic [4:0]  load_hour;
		logic [5:0]  load_minute;
		logic [5:0]  load_second;
		logic        logging_enabled;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  cur_second;
		logic [5:0]  cur_minute;
		logic [4:0]  cur_hour;
		logic [4:0]  cur_day;
		logic [3:0]  cur_month;
		logic [15:0] cur_year;
		logic        sync_due;
		logic        log_due;
	} out_item_t;

	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [15:0] year;
	} cal_time_t;

	// Gregorian rule: %100 is %4 and %25, %400 is %16 and %25
	function automatic logic is_leap(input logic [15:0] year);
		logic [15:0] prod;
		logic        div4;
		logic        div16;
		logic        div25;
		prod  = year * INV25_MOD16;
		div4  = (year[1:0] == 2'd0);
		div16 = (year[3:0] == 4'd0);
		div25 = (prod <= DIV25_LIMIT);
		return (div4 && !div25) || (div16 && div25);
	endfunction

	// Months outside 1..12 count as 31 days
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] n;
		case (month)
			4'd2:    n = leap ? 5'd29 : 5'd28;
			4'd4:    n = 5'd30;
			4'd6:    n = 5'd30;
			4'd9:    n = 5'd30;
			4'd11:   n = 5'd30;
			default: n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

[rtl/ccif_intf.sv]
// Valid/ready channel interfaces for the calendar clock block.
interface ccif_in_if;
	logic                valid;
	logic                ready;
	ccif_pkg::in_item_t  item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface ccif_out_if;
	logic                valid;
	logic                ready;
	ccif_pkg::out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

interface ccif_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ccif_pkg::CFG_IDX_W-1:0]    index;
	logic [ccif_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/calendar_clock_with_interval_flags.sv]
// Calendar clock with Gregorian leap years, resync-due and log-due pulses.
// Every input transfer (tick, load time, clear log counter or unused kind) yields exactly one
// result that shows the time after the item and the two pulse flags, which are set only on
// ticks. The block takes one item per clock cycle; a result is presented the cycle after its
// transfer and is held in a single output register, so input is accepted whenever that
// register is empty or being drained in the same cycle. The calendar carry chain with its
// leap-year test is combinational and sits between the time registers and the output
// register. Configuration writes are accepted every cycle.
module calendar_clock_with_interval_flags (
	input logic         clk,
	input logic         arst_n,
	ccif_in_if.sink     in_ch,
	ccif_out_if.source  out_ch,
	ccif_cfg_if.sink    cfg
);
	import ccif_pkg::*;

	cal_time_t   time_q;
	cal_time_t   tick_time;
	cal_time_t   time_n;
	logic [15:0] sync_ticks_q;
	logic [15:0] sync_ticks_n;
	logic [11:0] log_ticks_q;
	logic [11:0] log_ticks_n;
	logic [15:0] sync_period_q;
	logic [11:0] log_interval_q;

	logic        out_valid_q;
	out_item_t   out_q;

	logic        in_xfer;
	logic [15:0] sync_inc;
	logic        sync_hit;
	logic [11:0] log_inc;
	logic [11:0] log_thr;
	logic        log_hit;
	logic        sync_due_n;
	logic        log_due_n;

	ccif_calendar u_calendar (
		.cur (time_q),
		.nxt (tick_time)
	);

	assign in_ch.ready  = !out_valid_q || out_ch.ready;
	assign in_xfer      = in_ch.valid && in_ch.ready;
	assign cfg.ready    = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_q;

	// Period 0 fires on every tick, same as 1
	assign sync_inc = sync_ticks_q + 16'd1;
	assign sync_hit = (sync_inc >= sync_period_q);

	// Threshold compare runs even while logging is off
	assign log_inc = in_ch.item.logging_enabled ? log_ticks_q + 12'd1 : log_ticks_q;
	assign log_thr = ((log_interval_q < LOG_INTERVAL_MIN) ? LOG_INTERVAL_MIN : log_interval_q)
		- 12'd1;
	assign log_hit = (log_inc >= log_thr);

	always_comb begin
		time_n       = time_q;
		sync_ticks_n = sync_ticks_q;
		log_ticks_n  = log_ticks_q;
		sync_due_n   = 1'b0;
		log_due_n    = 1'b0;
		unique case (in_ch.item.kind)
			KIND_TICK: begin
				time_n       = tick_time;
				sync_ticks_n = sync_hit ? 16'd0 : sync_inc;
				log_ticks_n  = log_hit ? 12'd0 : log_inc;
				sync_due_n   = sync_hit;
				log_due_n    = log_hit;
			end
			KIND_LOAD: begin
				time_n.year   = in_ch.item.load_year;
				time_n.month  = in_ch.item.load_month;
				time_n.day    = in_ch.item.load_day;
				time_n.hour   = in_ch.item.load_hour;
				time_n.minute = in_ch.item.load_minute;
				time_n.second = in_ch.item.load_second;
			end
			KIND_CLEAR: begin
				log_ticks_n = 12'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q.second  <= 6'd0;
			time_q.minute  <= 6'd0;
			time_q.hour    <= 5'd0;
			time_q.day     <= 5'd1;
			time_q.month   <= 4'd1;
			time_q.year    <= YEAR_RESET;
			sync_ticks_q   <= 16'd0;
			log_ticks_q    <= 12'd0;
			sync_period_q  <= SYNC_PERIOD_RESET;
			log_interval_q <= LOG_INTERVAL_RESET;
			out_valid_q    <= 1'b0;
		end else begin
			if (in_xfer) begin
				time_q       <= time_n;
				sync_ticks_q <= sync_ticks_n;
				log_ticks_q  <= log_ticks_n;
				out_valid_q  <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q  <= 1'b0;
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_SYNC_PERIOD) begin
					sync_period_q <= cfg.data;
				end else if (cfg.index == REG_LOG_INTERVAL) begin
					log_interval_q <= cfg.data[11:0];
				end
			end
		end
	end

	// Result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_q.cur_second <= time_n.second;
			out_q.cur_minute <= time_n.minute;
			out_q.cur_hour   <= time_n.hour;
			out_q.cur_day    <= time_n.day;
			out_q.cur_month  <= time_n.month;
			out_q.cur_year   <= time_n.year;
			out_q.sync_due   <= sync_due_n;
			out_q.log_due    <= log_due_n;
		end
	end

	a_xfer_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> out_ch.valid)
		else $error("transfer did not produce a result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ch.ready)
		else $error("input stalled with empty output register");

	a_flags_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_ch.item.kind != KIND_TICK) |=> (!out_q.sync_due && !out_q.log_due))
		else $error("pulse flag set on a non-tick item");

	a_tick_second_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_ch.item.kind == KIND_TICK) |=> (out_q.cur_second < SEC_PER_MIN))
		else $error("second out of range after tick");

	a_sync_resets_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_ch.item.kind == KIND_TICK && sync_hit) |=> (sync_ticks_q == 16'd0))
		else $error("sync counter not cleared on pulse");

endmodule

[rtl/ccif_calendar.sv]
// One-second advance of the calendar time with carries and leap years.
module ccif_calendar (
	input  ccif_pkg::cal_time_t cur,
	output ccif_pkg::cal_time_t nxt
);
	import ccif_pkg::*;

	logic [5:0]  sec_inc;
	logic [5:0]  min_inc;
	logic [4:0]  hour_inc;
	logic [4:0]  day_inc;
	logic [3:0]  month_inc;
	logic        c_sec;
	logic        c_min;
	logic        c_hour;
	logic        c_day;
	logic        c_month;
	logic [4:0]  day_limit;

	// Length uses the month and year before this tick
	assign day_limit = month_days(cur.month, is_leap(cur.year));

	// Each stage compares even without an incoming carry, so oversized loads roll over
	always_comb begin
		sec_inc   = cur.second + 6'd1;
		c_sec     = (sec_inc >= SEC_PER_MIN);
		min_inc   = c_sec ? cur.minute + 6'd1 : cur.minute;
		c_min     = (min_inc >= MIN_PER_HOUR);
		hour_inc  = c_min ? cur.hour + 5'd1 : cur.hour;
		c_hour    = (hour_inc >= HOUR_PER_DAY);
		day_inc   = c_hour ? cur.day + 5'd1 : cur.day;
		c_day     = (day_inc > day_limit);
		month_inc = c_day ? cur.month + 4'd1 : cur.month;
		c_month   = (month_inc > MONTH_PER_YEAR);

		nxt.second = c_sec   ? 6'd0 : sec_inc;
		nxt.minute = c_min   ? 6'd0 : min_inc;
		nxt.hour   = c_hour  ? 5'd0 : hour_inc;
		nxt.day    = c_day   ? 5'd1 : day_inc;
		nxt.month  = c_month ? 4'd1 : month_inc;
		nxt.year   = c_month ? cur.year + 16'd1 : cur.year;
	end

endmodule

[test/tb_calendar_clock_with_interval_flags.sv]
// Testbench for the calendar clock: random and directed items checked against a modeled calendar.
module tb_calendar_clock_with_interval_flags;
	timeunit 1ns;
	timeprecision 1ps;

	import ccif_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 200000;
	localparam int STALL_CYCLES = 200;
	localparam int GAP_PCT = 36;
	localparam int MAX_REPORTS = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ccif_in_if  in_ch();
	ccif_out_if out_ch();
	ccif_cfg_if cfg_ch();

	calendar_clock_with_interval_flags i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// Modeled calendar and pulse counters
	logic [5:0]  cal_sec;
	logic [5:0]  cal_min;
	logic [4:0]  cal_hour;
	logic [4:0]  cal_day;
	logic [3:0]  cal_month;
	logic [15:0] cal_year;
	logic [15:0] resync_cnt;
	logic [11:0] log_cnt;
	logic [15:0] resync_period;
	logic [11:0] log_period;

	out_item_t pending_readouts[$];
	int errors = 0;
	int cycles = 0;
	int sent_items = 0;
	int stall_reqs = 0;
	int stall_served = 0;
	int stall_left = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic leap_year(input logic [15:0] y);
		return ((y % 16'd4 == 16'd0) && (y % 16'd100 != 16'd0)) || (y % 16'd400 == 16'd0);
	endfunction

	// Months outside 1..12 take 31 days
	function automatic logic [4:0] month_length(input logic [3:0] m, input logic [15:0] y);
		case (m)
			MONTH_FEB: return leap_year(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
			default: return 5'd31;
		endcase
	endfunction

	function automatic void reset_calendar();
		cal_sec = '0;
		cal_min = '0;
		cal_hour = '0;
		cal_day = 5'd1;
		cal_month = 4'd1;
		cal_year = YEAR_RESET;
		resync_cnt = '0;
		log_cnt = '0;
		resync_period = SYNC_PERIOD_RESET;
		log_period = LOG_INTERVAL_RESET;
	endfunction

	// Applies one item to the modeled calendar and returns the readout it yields
	function automatic out_item_t advance_calendar(input in_item_t it);
		out_item_t r;
		logic [11:0] thr;
		r = '0;
		case (it.kind)
			KIND_TICK: begin
				// counters wrap at their own widths, so oversized loads may skip a carry
				cal_sec = cal_sec + 6'd1;
				if (cal_sec >= SEC_PER_MIN) begin
					cal_sec = '0;
					cal_min = cal_min + 6'd1;
				end
				if (cal_min >= MIN_PER_HOUR) begin
					cal_min = '0;
					cal_hour = cal_hour + 5'd1;
				end
				if (cal_hour >= HOUR_PER_DAY) begin
					cal_hour = '0;
					cal_day = cal_day + 5'd1;
				end
				if (cal_day > month_length(cal_month, cal_year)) begin
					cal_day = 5'd1;
					cal_month = cal_month + 4'd1;
				end
				if (cal_month > MONTH_PER_YEAR) begin
					cal_month = 4'd1;
					cal_year = cal_year + 16'd1;
				end
				resync_cnt = resync_cnt + 16'd1;
				if (resync_cnt >= resync_period) begin
					r.sync_due = 1'b1;
					resync_cnt = '0;
				end
				if (it.logging_enabled)
					log_cnt = log_cnt + 12'd1;
				// threshold compare runs even with logging off
				thr = (log_period < LOG_INTERVAL_MIN ? LOG_INTERVAL_MIN : log_period) - 12'd1;
				if (log_cnt >= thr) begin
					r.log_due = 1'b1;
					log_cnt = '0;
				end
			end
			KIND_LOAD: begin
				cal_year = it.load_year;
				cal_month = it.load_month;
				cal_day = it.load_day;
				cal_hour = it.load_hour;
				cal_min = it.load_minute;
				cal_sec = it.load_second;
			end
			KIND_CLEAR: log_cnt = '0;
			default: ;
		endcase
		r.cur_second = cal_sec;
		r.cur_minute = cal_min;
		r.cur_hour = cal_hour;
		r.cur_day = cal_day;
		r.cur_month = cal_month;
		r.cur_year = cal_year;
		return r;
	endfunction

	function automatic string show(input out_item_t r);
		return $sformatf("%0d-%0d-%0d %0d:%0d:%0d sync=%0b log=%0b", r.cur_year, r.cur_month,
			r.cur_day, r.cur_hour, r.cur_minute, r.cur_second, r.sync_due, r.log_due);
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s", $time, msg);
	endtask

	// Readout checker and receiver-side flow control
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got = out_ch.item;
			if (pending_readouts.size() == 0) begin
				report($sformatf("readout with nothing pending: %s", show(got)));
			end else begin
				want = pending_readouts.pop_front();
				if (got.cur_second !== want.cur_second || got.cur_minute !== want.cur_minute ||
				    got.cur_hour !== want.cur_hour || got.cur_day !== want.cur_day ||
				    got.cur_month !== want.cur_month || got.cur_year !== want.cur_year ||
				    got.sync_due !== want.sync_due || got.log_due !== want.log_due)
					report($sformatf("readout mismatch: expected %s, got %s", show(want),
						show(got)));
			end
		end
		out_ch.ready <= (stall_left == 0) && (rx_steady || $urandom_range(99) >= GAP_PCT);
	end

	// Long receiver hold-off, one per request
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_served != stall_reqs) begin
			stall_left <= STALL_CYCLES;
			stall_served <= stall_served + 1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_item(input in_item_t it);
		logic [63:0] junk;
		if (!tx_steady) begin
			while ($urandom_range(99) < GAP_PCT) begin
				junk = {$urandom, $urandom};
				in_ch.valid <= 1'b0;
				in_ch.item <= junk[$bits(in_item_t)-1:0];
				@(posedge clk);
			end
		end
		in_ch.valid <= 1'b1;
		in_ch.item <= it;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		pending_readouts.push_back(advance_calendar(it));
		sent_items++;
	endtask

	// Register writes only once every readout is back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		in_ch.valid <= 1'b0;
		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_SYNC_PERIOD: resync_period = data;
			REG_LOG_INTERVAL: log_period = data[11:0];
			default: ;
		endcase
	endtask

	function automatic in_item_t any_item(input logic [1:0] k);
		logic [63:0] r;
		in_item_t it;
		r = {$urandom, $urandom};
		it = r[$bits(in_item_t)-1:0];
		it.kind = k;
		return it;
	endfunction

	task automatic send_tick(input bit en);
		in_item_t it;
		it = any_item(KIND_TICK);
		it.logging_enabled = en;
		send_item(it);
	endtask

	task automatic send_load(input logic [15:0] y, input logic [3:0] mo, input logic [4:0] d,
		input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
		in_item_t it;
		it = any_item(KIND_LOAD);
		it.load_year = y;
		it.load_month = mo;
		it.load_day = d;
		it.load_hour = h;
		it.load_minute = mi;
		it.load_second = s;
		send_item(it);
	endtask

	// Load a few seconds before midnight on or near a month end, then tick through it
	task automatic send_near_rollover();
		logic [15:0] y;
		logic [3:0] mo;
		logic [4:0] d;
		case ($urandom_range(5))
			0: y = 16'($urandom);
			1: y = 16'hFFFF;
			2: y = 16'(400 * $urandom_range(163));
			3: y = 16'(100 * $urandom_range(655));
			4: y = 16'(4 * $urandom_range(16383));
			default: y = 16'(1999 + $urandom_range(30));
		endcase
		if ($urandom_range(9) == 0)
			mo = 4'($urandom_range(15));
		else
			mo = 4'($urandom_range(12, 1));
		d = month_length(mo, y) - 5'($urandom_range(1));
		if ($urandom_range(7) == 0)
			d = 5'd31;
		send_load(y, mo, d, 5'd23, 6'd59, 6'(55 + $urandom_range(4)));
		repeat ($urandom_range(12, 3)) send_tick($urandom_range(3) != 0);
	endtask

	task automatic run_traffic(input int n);
		int stop_at;
		int pick;
		stop_at = sent_items + n;
		while (sent_items < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_near_rollover();
			end else if (pick < 68) begin
				repeat ($urandom_range(20, 1)) send_tick($urandom_range(3) != 0);
			end else if (pick < 76) begin
				send_item(any_item(KIND_CLEAR));
			end else if (pick < 82) begin
				send_item(any_item(KIND_UNUSED));
			end else if (pick < 92) begin
				// arbitrary field values, out of range included
				send_item(any_item(KIND_LOAD));
				repeat ($urandom_range(6, 1)) send_tick(1'b1);
			end else begin
				send_load(16'($urandom), 4'($urandom_range(12, 1)), 5'($urandom_range(28, 1)),
					5'($urandom_range(23)), 6'($urandom_range(59)), 6'($urandom_range(59)));
				repeat ($urandom_range(8, 1)) send_tick($urandom_range(1));
			end
		end
	endtask

	task automatic test_reset_state();
		send_item(any_item(KIND_UNUSED));
		repeat (5) send_tick(1'b1);
		send_item(any_item(KIND_CLEAR));
		send_tick(1'b1);
	endtask

	task automatic test_calendar_edges();
		// year wrap through an oversized month
		send_load(16'hFFFF, 4'd13, 5'd31, 5'd23, 6'd59, 6'd59);
		send_tick(1'b1);
		send_load(16'd2000, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59);
		send_tick(1'b0);
		send_load(16'd1900, MONTH_FEB, 5'd28, 5'd23, 6'd59, 6'd59);
		send_tick(1'b1);
		send_load(16'd2024, MONTH_FEB, 5'd29, 5'd23, 6'd59, 6'd59);
		send_tick(1'b1);
		send_load(16'd2023, 4'd11, 5'd30, 5'd23, 6'd59, 6'd59);
		send_tick(1'b0);
		send_load(16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
		send_tick(1'b1);
		send_load(16'hFFFF, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
		send_tick(1'b1);
		send_tick(1'b1);
		// day past a 30-day month end wraps its counter instead of carrying
		send_load(16'd2001, 4'd4, 5'd31, 5'd23, 6'd59, 6'd59);
		send_tick(1'b1);
		send_item(any_item(KIND_UNUSED));
	endtask

	task automatic test_log_while_disabled();
		write_reg(REG_SYNC_PERIOD, 16'd3);
		write_reg(REG_LOG_INTERVAL, 16'd40);
		repeat (12) send_tick(1'b1);
		// lowering the interval below the count fires on the next tick, logging off
		write_reg(REG_LOG_INTERVAL, 16'd5);
		send_tick(1'b0);
		send_tick(1'b0);
	endtask

	task automatic test_output_stall();
		tx_steady = 1'b1;
		rx_steady <= 1'b1;
		stall_reqs <= stall_reqs + 1;
		repeat (40) send_tick($urandom_range(1));
		tx_steady = 1'b0;
		rx_steady <= 1'b0;
	endtask

	task automatic test_random_phases();
		logic [15:0] sync_set[8];
		logic [11:0] log_set[8];
		logic [15:0] sync_val;
		sync_set = '{16'd1, 16'd0, 16'd2, 16'd65535, 16'd7, 16'd60, 16'd900, 16'd13};
		log_set = '{12'd5, 12'd0, 12'd4095, 12'd3600, 12'd6, 12'd4, 12'd12, 12'd7};
		for (int p = 0; p < 8; p++) begin
			sync_val = (p == 7) ? 16'($urandom_range(65535, 1)) : sync_set[p];
			write_reg(REG_SYNC_PERIOD, sync_val);
			write_reg(REG_LOG_INTERVAL, {4'($urandom_range(15)), log_set[p]});
			// one phase runs with no gaps on either side
			tx_steady = (p == 2);
			rx_steady <= (p == 2);
			run_traffic(95);
		end
		tx_steady = 1'b0;
		rx_steady <= 1'b0;
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.item = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		reset_calendar();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_calendar_edges();
		test_log_while_disabled();
		test_output_stall();
		test_random_phases();
		in_ch.valid <= 1'b0;
		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[sim.f]
rtl/ccif_pkg.sv
rtl/ccif_intf.sv
rtl/ccif_calendar.sv
rtl/calendar_clock_with_interval_flags.sv
test/tb_calendar_clock_with_interval_flags.sv
